### rtl/rsfg_pkg.sv
// rsfg_pkg: shared types, constants, gamma lookup and divide-by-255 functions for the RGB strip
// frame generator. No dependencies.
`timescale 1ns / 1ps

package rsfg_pkg;

    localparam int LED_COUNT   = 26;
    localparam int CLEAR_COUNT = 1;
    localparam int FRAME_WORDS = LED_COUNT + CLEAR_COUNT;
    localparam int CNT_W       = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;

    typedef enum logic [2:0] {
        ACT_SET_LEVEL  = 3'd0,
        ACT_SET_COLOUR = 3'd1,
        ACT_TURN_ON    = 3'd2,
        ACT_TURN_OFF   = 3'd3,
        ACT_START      = 3'd4
    } t_action;

    typedef struct packed {
        logic       lamp_on;
        logic       started;
        logic [7:0] level;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_state;

    localparam t_state STATE_RESET = '{
        lamp_on: 1'b0, started: 1'b0, level: 8'd127,
        red: 8'd64, green: 8'd64, blue: 8'd64
    };

    // Frame request handed to the word emitter
    typedef struct packed {
        logic        valid;
        logic [23:0] pix;
    } t_frame_req;

    localparam logic [7:0] GAMMA [256] = '{
        8'd128,8'd128,8'd128,8'd128,8'd128,8'd128,8'd128,8'd128,
        8'd128,8'd128,8'd128,8'd128,8'd128,8'd128,8'd128,8'd128,
        8'd128,8'd128,8'd128,8'd128,8'd128,8'd128,8'd128,8'd128,
        8'd128,8'd128,8'd128,8'd128,8'd129,8'd129,8'd129,8'd129,
        8'd129,8'd129,8'd129,8'd129,8'd129,8'd129,8'd129,8'd129,
        8'd129,8'd129,8'd129,8'd129,8'd130,8'd130,8'd130,8'd130,
        8'd130,8'd130,8'd130,8'd130,8'd130,8'd131,8'd131,8'd131,
        8'd131,8'd131,8'd131,8'd131,8'd131,8'd132,8'd132,8'd132,
        8'd132,8'd132,8'd132,8'd132,8'd133,8'd133,8'd133,8'd133,
        8'd133,8'd134,8'd134,8'd134,8'd134,8'd134,8'd135,8'd135,
        8'd135,8'd135,8'd135,8'd136,8'd136,8'd136,8'd136,8'd137,
        8'd137,8'd137,8'd137,8'd138,8'd138,8'd138,8'd138,8'd139,
        8'd139,8'd139,8'd140,8'd140,8'd140,8'd141,8'd141,8'd141,
        8'd141,8'd142,8'd142,8'd142,8'd143,8'd143,8'd144,8'd144,
        8'd144,8'd145,8'd145,8'd145,8'd146,8'd146,8'd146,8'd147,
        8'd147,8'd148,8'd148,8'd149,8'd149,8'd149,8'd150,8'd150,
        8'd151,8'd151,8'd152,8'd152,8'd152,8'd153,8'd153,8'd154,
        8'd154,8'd155,8'd155,8'd156,8'd156,8'd157,8'd157,8'd158,
        8'd158,8'd159,8'd160,8'd160,8'd161,8'd161,8'd162,8'd162,
        8'd163,8'd163,8'd164,8'd165,8'd165,8'd166,8'd166,8'd167,
        8'd168,8'd168,8'd169,8'd169,8'd170,8'd171,8'd171,8'd172,
        8'd173,8'd173,8'd174,8'd175,8'd175,8'd176,8'd177,8'd178,
        8'd178,8'd179,8'd180,8'd180,8'd181,8'd182,8'd183,8'd183,
        8'd184,8'd185,8'd186,8'd186,8'd187,8'd188,8'd189,8'd190,
        8'd190,8'd191,8'd192,8'd193,8'd194,8'd195,8'd195,8'd196,
        8'd197,8'd198,8'd199,8'd200,8'd201,8'd202,8'd202,8'd203,
        8'd204,8'd205,8'd206,8'd207,8'd208,8'd209,8'd210,8'd211,
        8'd212,8'd213,8'd214,8'd215,8'd216,8'd217,8'd218,8'd219,
        8'd220,8'd221,8'd222,8'd223,8'd224,8'd225,8'd226,8'd227,
        8'd228,8'd229,8'd230,8'd232,8'd233,8'd234,8'd235,8'd236,
        8'd237,8'd238,8'd239,8'd241,8'd242,8'd243,8'd244,8'd245,
        8'd246,8'd248,8'd249,8'd250,8'd251,8'd253,8'd254,8'd255
    };

    function automatic logic [7:0] gamma_lut(input logic [7:0] idx);
        return GAMMA[idx];
    endfunction

    // x / 255 for x <= 255*255: (x + (x >> 8) + 1) >> 8
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

### rtl/rsfg_emit.sv
// rsfg_emit: frame word sequencer with registered output stage.
// Depends on rsfg_pkg.
`timescale 1ns / 1ps

module rsfg_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsfg_pkg::t_frame_req i_req,
    output logic                 o_take,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [23:0]          o_word,
    output logic                 o_is_pixel,
    output logic                 o_last
);
    import rsfg_pkg::*;

    logic             r_active;
    logic [CNT_W-1:0] r_cnt;
    logic [23:0]      r_pix;
    logic             r_valid;
    logic [23:0]      r_word;
    logic             r_is_pixel;
    logic             r_last;
    logic             out_free;
    logic             cur_pixel;
    logic             cur_last;

    assign out_free  = !r_valid || i_ready;
    // next frame is taken as the last word of the current one is loaded
    assign o_take    = i_req.valid && (!r_active || (out_free && cur_last));
    assign cur_pixel = (r_cnt >= CNT_W'(CLEAR_COUNT));
    assign cur_last  = (r_cnt == CNT_W'(FRAME_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (o_take) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (r_active && out_free) begin
                if (cur_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (out_free) begin
                r_valid <= r_active;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pix <= i_req.pix;
        end
        if (out_free && r_active) begin
            r_word     <= cur_pixel ? r_pix : 24'd0;
            r_is_pixel <= cur_pixel;
            r_last     <= cur_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_word     = r_word;
    assign o_is_pixel = r_is_pixel;
    assign o_last     = r_last;

endmodule

### rtl/rgb_strip_frame_generator_top.sv
// rgb_strip_frame_generator_top: event-driven LED strip frame generator.
// Depends on rsfg_pkg and rsfg_emit.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_valid / o_ready): one beat is one event (set level,
//   set colour, turn on, turn off, start) with its level and colour bytes.
//   Output channel (o_valid / i_ready): one beat per shifted word. A frame
//   is CLEAR_COUNT clear bytes (is_pixel = 0, word = 0) followed by
//   LED_COUNT identical pixel words; last marks the final pixel word.
// Path: when the word sequencer is idle, the first word of a frame goes from
//   the event beat through stage A, stage B, the sequencer and its output register.
// Throughput: one word per cycle while i_ready is high; a frame event holds the
//   sequencer for CLEAR_COUNT + LED_COUNT words, and the next frame starts right
//   after the last word. Colour math (multiply, /255, gamma) runs in two stages
//   that overlap the current frame; no event is taken while a frame is in either
//   stage, and events that produce no frame are taken every cycle otherwise.
// State: one entry in a synchronous memory with a registered read; the write
//   is forwarded into the read register, and a valid bit makes it read as
//   the reset state until first written.
// Reset: synchronous active-low; clears the pipeline, the sequencer and the
//   state valid bit (lamp off, not started, level 127, colour 64/64/64).
// Stall: when i_ready is low the output beat holds; the sequencer halts and
//   at most one further frame waits in the colour stage, with o_ready low.

module rgb_strip_frame_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_level,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_word,
    output logic        o_is_pixel,
    output logic        o_last
);
    import rsfg_pkg::*;

    // state memory, one entry
    t_state     r_state_mem [1];
    t_state     r_state_rd;
    logic       r_state_vld;
    t_state     cur_state;
    t_state     n_state;
    logic       frame_req;
    logic       accept;

    // stage A: products
    logic        r_a_v;
    logic        r_a_lamp;
    logic [15:0] r_a_prod_r;
    logic [15:0] r_a_prod_g;
    logic [15:0] r_a_prod_b;

    // stage B: /255 and gamma lookups
    logic        r_b_v;
    logic        r_b_lamp;
    logic [7:0]  r_b_r;
    logic [7:0]  r_b_g;
    logic [7:0]  r_b_b;

    t_frame_req  req;
    logic        take;

    assign o_ready   = !r_a_v && !r_b_v;
    assign accept    = i_valid && o_ready;
    assign cur_state = r_state_vld ? r_state_rd : STATE_RESET;

    // event decode
    always_comb begin
        n_state   = cur_state;
        frame_req = 1'b0;
        unique case (i_action)
            ACT_SET_LEVEL: begin
                if (i_level != cur_state.level) begin
                    n_state.level = (i_level == 8'd0) ? 8'd1 : i_level;
                    frame_req     = cur_state.lamp_on;
                end
            end
            ACT_SET_COLOUR: begin
                if (i_red != cur_state.red || i_green != cur_state.green ||
                    i_blue != cur_state.blue) begin
                    n_state.red   = i_red;
                    n_state.green = i_green;
                    n_state.blue  = i_blue;
                    frame_req     = cur_state.lamp_on;
                end
            end
            ACT_TURN_ON: begin
                if (!cur_state.lamp_on) begin
                    n_state.lamp_on = 1'b1;
                    frame_req       = 1'b1;
                end
            end
            ACT_TURN_OFF: begin
                if (cur_state.lamp_on) begin
                    n_state.lamp_on = 1'b0;
                    frame_req       = 1'b1;
                end
            end
            ACT_START: begin
                if (!cur_state.started) begin
                    n_state.lamp_on = 1'b1;
                    n_state.started = 1'b1;
                    frame_req       = 1'b1;
                end
            end
            default: begin
                // unused action codes are ignored
            end
        endcase
    end

    // state memory write, registered read with write forwarding
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_state_mem[0] <= n_state;
        end
        r_state_rd <= accept ? n_state : r_state_mem[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_vld <= 1'b0;
        end else if (accept) begin
            r_state_vld <= 1'b1;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            r_a_v <= accept && frame_req;
            if (r_a_v) begin
                r_b_v <= 1'b1;
            end else if (take) begin
                r_b_v <= 1'b0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_lamp   <= n_state.lamp_on;
            r_a_prod_r <= n_state.red   * n_state.level;
            r_a_prod_g <= n_state.green * n_state.level;
            r_a_prod_b <= n_state.blue  * n_state.level;
        end
        if (r_a_v) begin
            r_b_lamp <= r_a_lamp;
            r_b_r    <= gamma_lut(div255(r_a_prod_r));
            r_b_g    <= gamma_lut(div255(r_a_prod_g));
            r_b_b    <= gamma_lut(div255(r_a_prod_b));
        end
    end

    assign req.valid = r_b_v;
    assign req.pix   = r_b_lamp ? {r_b_b, r_b_r, r_b_g} : 24'd0;

    rsfg_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_take     (take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word     (o_word),
        .o_is_pixel (o_is_pixel),
        .o_last     (o_last)
    );

endmodule

### rtl/rsfg_checker.sv
// rsfg_checker: port-level assertions for the frame generator, bound to the
// top level. Depends on rgb_strip_frame_generator_top.
`timescale 1ns / 1ps

module rsfg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [23:0] o_word,
    input logic        o_is_pixel,
    input logic        o_last
);

    // output beat holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word) && $stable(o_last))
        else $error("output beat changed while stalled");

    // clear bytes carry zero and never end a frame
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_pixel |-> o_word == 24'd0 && !o_last)
        else $error("bad clear byte");

    // inside a frame words come without gaps
    a_nogap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid)
        else $error("gap inside frame");

    // reset empties the output stage
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind rgb_strip_frame_generator_top rsfg_checker u_rsfg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_word     (o_word),
    .o_is_pixel (o_is_pixel),
    .o_last     (o_last)
);
